[hw/rtl/gnd_pkg.sv]
// Shared constants, types and helpers for the gather-ND address generator.
// No dependencies; every other file of the block imports this package.
package gnd_pkg;

	localparam int MAX_RANK = 4;
	localparam int DIM_BITS = 16;
	localparam int OFF_BITS = 32;
	localparam int IDX_BITS = 32;
	localparam int TPB_BITS = 32;
	localparam int RANK_W   = $clog2(MAX_RANK);
	localparam int CNT_W    = 2;
	localparam int OUT_W    = 3 * OFF_BITS;

	// register file geometry
	localparam int CFG_IDX_W    = 3;
	localparam int CFG_W        = 32;
	localparam int DATA_RANK_W  = 3;
	localparam int BATCH_DIMS_W = 2;
	localparam int TUPLE_LEN_W  = 3;

	localparam logic [CFG_IDX_W-1:0] REG_DATA_RANK        = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BATCH_DIMS       = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TUPLE_LEN        = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_DIM_SIZE_0       = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_DIM_SIZE_1       = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_DIM_SIZE_2       = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_DIM_SIZE_3       = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_TUPLES_PER_BATCH = 3'd7;

	// cycles the stride products need after a register write
	localparam int SETTLE   = 2;
	localparam int SETTLE_W = $clog2(SETTLE + 1);

	typedef logic [OFF_BITS-1:0] off_t;
	typedef logic [DIM_BITS-1:0] dim_t;

	localparam off_t OFF_MAX = '1;

	typedef struct packed {
		logic                              busy;
		logic [BATCH_DIMS_W-1:0]           lead_dims;
		logic [TUPLE_LEN_W-1:0]            tuple_len;   // clamped to 1..4
		logic [MAX_RANK-1:0][DIM_BITS-1:0] dim;         // sizes, 1 beyond the rank
		logic [MAX_RANK-1:0][OFF_BITS-1:0] stride;
		logic                              init_err;    // geometry or stride overflow
		off_t                              slice;
		logic                              slice_sat;
		logic [TPB_BITS-1:0]               tpb;         // zero already mapped to one
	} cfg_t;

	// per-item data only the tuple's last component needs
	typedef struct packed {
		off_t                slice;
		logic                slice_sat;
		logic                bvalid;
		off_t                bstride;
		logic [TPB_BITS-1:0] tpb;
	} fin_t;

	typedef struct packed {
		logic                first;
		logic                last;
		logic                dvalid;
		logic                init_err;
		logic [IDX_BITS-1:0] idx;
		dim_t                dim;
		off_t                stride;
		fin_t                fin;
	} item_t;

	typedef struct packed {
		logic first;
		logic last;
		logic dvalid;
		logic init_err;
		logic inr;
		dim_t v;
		off_t stride;
		fin_t fin;
	} rng_t;

	typedef struct packed {
		logic first;
		logic last;
		logic dvalid;
		logic init_err;
		logic inr;
		off_t term;
		logic term_sat;
		fin_t fin;
	} prod_t;

	// saturating multiply, result is {saturated, value}
	function automatic logic [OFF_BITS:0] smul(input off_t a, input dim_t b);
		logic [OFF_BITS+DIM_BITS-1:0] p;
		begin
			p = (OFF_BITS+DIM_BITS)'(a) * (OFF_BITS+DIM_BITS)'(b);
			if (|p[OFF_BITS+DIM_BITS-1:OFF_BITS]) begin
				smul = {1'b1, OFF_MAX};
			end else begin
				smul = {1'b0, p[OFF_BITS-1:0]};
			end
		end
	endfunction

endpackage

[hw/rtl/gnd_cfg.sv]
// Register file and derived geometry: effective sizes, row-major strides,
// slice length and the settle counter. Depends on gnd_pkg.
module gnd_cfg import gnd_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_wdata,
	output cfg_t                 cfg
);

	logic [DATA_RANK_W-1:0]            rank_q;
	logic [BATCH_DIMS_W-1:0]           bd_q;
	logic [TUPLE_LEN_W-1:0]            len_q;
	logic [MAX_RANK-1:0][DIM_BITS-1:0] dim_q;
	logic [TPB_BITS-1:0]               tpb_q;
	logic [SETTLE_W-1:0]               settle_q;
	off_t                              p2_q;
	off_t                              p1_q;
	logic                              s1_q;

	logic [DATA_RANK_W-1:0]            rank_eff;
	logic [TUPLE_LEN_W-1:0]            len_eff;
	logic [MAX_RANK-1:0][DIM_BITS-1:0] dim_eff;
	off_t                              p3;
	logic                              geom_ok;
	logic [3:0]                        slice_pos;
	logic [OFF_BITS:0]                 p2_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rank_q   <= DATA_RANK_W'(1);
			bd_q     <= '0;
			len_q    <= TUPLE_LEN_W'(1);
			dim_q    <= {MAX_RANK{DIM_BITS'(1)}};
			tpb_q    <= TPB_BITS'(1);
			settle_q <= SETTLE_W'(SETTLE);
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_DATA_RANK:        rank_q   <= cfg_wdata[DATA_RANK_W-1:0];
					REG_BATCH_DIMS:       bd_q     <= cfg_wdata[BATCH_DIMS_W-1:0];
					REG_TUPLE_LEN:        len_q    <= cfg_wdata[TUPLE_LEN_W-1:0];
					REG_DIM_SIZE_0:       dim_q[0] <= cfg_wdata[DIM_BITS-1:0];
					REG_DIM_SIZE_1:       dim_q[1] <= cfg_wdata[DIM_BITS-1:0];
					REG_DIM_SIZE_2:       dim_q[2] <= cfg_wdata[DIM_BITS-1:0];
					REG_DIM_SIZE_3:       dim_q[3] <= cfg_wdata[DIM_BITS-1:0];
					REG_TUPLES_PER_BATCH: tpb_q    <= cfg_wdata[TPB_BITS-1:0];
					default: ;
				endcase
				settle_q <= SETTLE_W'(SETTLE);
			end else if (settle_q != '0) begin
				settle_q <= settle_q - SETTLE_W'(1);
			end
		end
	end

	always_comb begin
		if (rank_q == '0) begin
			rank_eff = DATA_RANK_W'(1);
		end else if (rank_q > DATA_RANK_W'(MAX_RANK)) begin
			rank_eff = DATA_RANK_W'(MAX_RANK);
		end else begin
			rank_eff = rank_q;
		end
		if (len_q == '0) begin
			len_eff = TUPLE_LEN_W'(1);
		end else if (len_q > TUPLE_LEN_W'(4)) begin
			len_eff = TUPLE_LEN_W'(4);
		end else begin
			len_eff = len_q;
		end
		for (int k = 0; k < MAX_RANK; k++) begin
			dim_eff[k] = (DATA_RANK_W'(k) < rank_eff) ? dim_q[k] : DIM_BITS'(1);
		end
	end

	assign p3      = OFF_BITS'(dim_eff[3]);
	assign p2_full = smul(p3, dim_eff[2]);

	// suffix products: p2 = d3*d2, p1 = p2*d1, one register each
	always_ff @(posedge clk) begin
		p2_q         <= p2_full[OFF_BITS-1:0];
		{s1_q, p1_q} <= smul(p2_q, dim_eff[1]);
	end

	assign geom_ok = (rank_q >= DATA_RANK_W'(1)) && (rank_q <= DATA_RANK_W'(MAX_RANK)) &&
		(len_q >= TUPLE_LEN_W'(1)) && (len_q <= TUPLE_LEN_W'(4)) &&
		(DATA_RANK_W'(bd_q) < rank_q) &&
		((4'(bd_q) + 4'(len_q)) <= 4'(rank_q));

	assign slice_pos = 4'(bd_q) + 4'(len_eff);

	always_comb begin
		cfg.busy       = (settle_q != '0);
		cfg.lead_dims  = bd_q;
		cfg.tuple_len  = len_eff;
		cfg.dim        = dim_eff;
		cfg.stride[3]  = OFF_BITS'(1);
		cfg.stride[2]  = p3;
		cfg.stride[1]  = p2_q;
		cfg.stride[0]  = p1_q;
		// only the stride of dimension zero can overflow; it is used when the
		// first looked-up dimension is zero or as the batch stride of one leading dimension
		cfg.init_err   = !geom_ok || ((bd_q <= BATCH_DIMS_W'(1)) && s1_q);
		cfg.tpb        = (tpb_q == '0) ? TPB_BITS'(1) : tpb_q;
		case (slice_pos)
			4'd1: begin
				cfg.slice     = p1_q;
				cfg.slice_sat = s1_q;
			end
			4'd2: begin
				cfg.slice     = p2_q;
				cfg.slice_sat = 1'b0;
			end
			4'd3: begin
				cfg.slice     = p3;
				cfg.slice_sat = 1'b0;
			end
			default: begin
				cfg.slice     = OFF_BITS'(1);
				cfg.slice_sat = 1'b0;
			end
		endcase
	end

endmodule

[hw/rtl/gnd_issue.sv]
// Input register: component counter, per-tuple stride latch and capture of
// all geometry an item needs. Depends on gnd_pkg.
module gnd_issue import gnd_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  cfg_t                cfg,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [IDX_BITS-1:0] s_tdata,
	input  logic                rdy_next,
	output logic                v_s1,
	output item_t               item_s1
);

	logic [CNT_W-1:0]                  cc_q;
	logic [MAX_RANK-1:0][OFF_BITS-1:0] tstride_q;

	logic                              accept;
	logic                              first;
	logic                              last;
	logic [2:0]                        d;
	logic [RANK_W-1:0]                 dsel;
	logic [MAX_RANK-1:0][OFF_BITS-1:0] stride_cur;
	item_t                             item;

	assign s_tready = !cfg.busy && (!v_s1 || rdy_next);
	assign accept   = s_tvalid && s_tready;

	always_comb begin
		first      = (cc_q == '0);
		last       = ((3'(cc_q) + 3'd1) >= cfg.tuple_len);
		d          = 3'(cfg.lead_dims) + 3'(cc_q);
		dsel       = d[RANK_W-1:0];
		// strides are taken fresh on a tuple's first item, latched otherwise
		stride_cur = first ? cfg.stride : tstride_q;

		item.first         = first;
		item.last          = last;
		item.dvalid        = (d < 3'(MAX_RANK));
		item.init_err      = cfg.init_err;
		item.idx           = s_tdata;
		item.dim           = cfg.dim[dsel];
		item.stride        = stride_cur[dsel];
		item.fin.slice     = cfg.slice;
		item.fin.slice_sat = cfg.slice_sat;
		item.fin.bvalid    = (cfg.lead_dims != '0);
		item.fin.bstride   = stride_cur[cfg.lead_dims - BATCH_DIMS_W'(1)];
		item.fin.tpb       = cfg.tpb;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cc_q <= '0;
			v_s1 <= 1'b0;
		end else begin
			if (accept) begin
				cc_q <= last ? '0 : cc_q + CNT_W'(1);
				v_s1 <= 1'b1;
			end else if (rdy_next) begin
				v_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= item;
			if (first) begin
				tstride_q <= cfg.stride;
			end
		end
	end

endmodule

[hw/rtl/gnd_term.sv]
// Two pipeline stages: negative-index wrap with range check, then the
// saturating component-times-stride product. Depends on gnd_pkg.
module gnd_term import gnd_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  v_s1,
	input  item_t item_s1,
	output logic  rdy,
	input  logic  rdy_next,
	output logic  v_s3,
	output prod_t prod_s3
);

	logic              v_s2;
	rng_t              rng_s2;
	logic              rdy3;
	logic [IDX_BITS:0] idx_x;
	logic [IDX_BITS:0] dim_x;
	logic [IDX_BITS:0] w;
	rng_t              rng;
	prod_t             prod;

	assign rdy3 = !v_s3 || rdy_next;
	assign rdy  = !v_s2 || rdy3;

	always_comb begin
		idx_x = {item_s1.idx[IDX_BITS-1], item_s1.idx};
		dim_x = (IDX_BITS+1)'(item_s1.dim);
		w     = item_s1.idx[IDX_BITS-1] ? idx_x + dim_x : idx_x;

		rng.first    = item_s1.first;
		rng.last     = item_s1.last;
		rng.dvalid   = item_s1.dvalid;
		rng.init_err = item_s1.init_err;
		rng.inr      = !w[IDX_BITS] && (w < dim_x);
		rng.v        = w[DIM_BITS-1:0];
		rng.stride   = item_s1.stride;
		rng.fin      = item_s1.fin;

		prod.first              = rng_s2.first;
		prod.last               = rng_s2.last;
		prod.dvalid             = rng_s2.dvalid;
		prod.init_err           = rng_s2.init_err;
		prod.inr                = rng_s2.inr;
		{prod.term_sat, prod.term} = smul(rng_s2.stride, rng_s2.v);
		prod.fin                = rng_s2.fin;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (rdy) begin
				v_s2 <= v_s1;
			end
			if (rdy3) begin
				v_s3 <= v_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy && v_s1) begin
			rng_s2 <= rng;
		end
		if (rdy3 && v_s2) begin
			prod_s3 <= prod;
		end
	end

endmodule

[hw/rtl/gnd_accum.sv]
// Tuple accumulation, batch base and destination bookkeeping, and the
// output register. Depends on gnd_pkg.
module gnd_accum import gnd_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             v_s3,
	input  prod_t            prod_s3,
	output logic             rdy,
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [OUT_W-1:0] m_tdata,
	output logic             m_tuser
);

	off_t                part_q;
	logic                terr_q;
	off_t                base_q;
	off_t                dest_q;
	logic [TPB_BITS-1:0] tib_q;

	logic                v_s4;
	off_t                part_s4;
	logic                err_s4;
	fin_t                fin_s4;

	logic                out_vld_q;
	off_t                out_src_q;
	off_t                out_dst_q;
	off_t                out_len_q;
	logic                out_err_q;

	logic                rdy_out;
	logic                fire3;
	logic                fire4;
	off_t                base_p;
	logic                base_e;
	logic [OFF_BITS:0]   sum_a;
	off_t                p_new;
	logic                e_new;
	logic [OFF_BITS:0]   sum_src;
	logic [OFF_BITS:0]   sum_dst;
	logic [OFF_BITS:0]   sum_base;
	logic [TPB_BITS:0]   tib_inc;
	logic                wrap;
	logic                sat_fin;

	assign rdy_out = !out_vld_q || m_tready;
	assign rdy     = !v_s4 || rdy_out;
	assign fire3   = v_s3 && rdy;
	assign fire4   = v_s4 && rdy_out;

	always_comb begin
		base_p = prod_s3.first ? '0 : part_q;
		base_e = prod_s3.first ? prod_s3.init_err : terr_q;
		sum_a  = {1'b0, base_p} + {1'b0, prod_s3.term};
		p_new  = base_p;
		e_new  = base_e;
		// a component past the last data dimension adds nothing
		if (prod_s3.dvalid) begin
			if (!prod_s3.inr) begin
				e_new = 1'b1;
			end else if (prod_s3.term_sat || sum_a[OFF_BITS]) begin
				p_new = OFF_MAX;
				e_new = 1'b1;
			end else begin
				p_new = sum_a[OFF_BITS-1:0];
			end
		end
	end

	always_comb begin
		sat_fin  = (base_q == OFF_MAX) || (dest_q == OFF_MAX) || fin_s4.slice_sat;
		sum_src  = {1'b0, base_q} + {1'b0, part_s4};
		sum_dst  = {1'b0, dest_q} + {1'b0, fin_s4.slice};
		sum_base = {1'b0, base_q} + {1'b0, fin_s4.bstride};
		tib_inc  = {1'b0, tib_q} + (TPB_BITS+1)'(1);
		wrap     = (tib_inc >= {1'b0, fin_s4.tpb});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			part_q    <= '0;
			terr_q    <= 1'b0;
			base_q    <= '0;
			dest_q    <= '0;
			tib_q     <= '0;
			v_s4      <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (fire3) begin
				part_q <= p_new;
				terr_q <= e_new;
			end
			if (rdy) begin
				v_s4 <= fire3 && prod_s3.last;
			end
			if (fire4) begin
				dest_q <= sum_dst[OFF_BITS] ? OFF_MAX : sum_dst[OFF_BITS-1:0];
				tib_q  <= wrap ? '0 : tib_inc[TPB_BITS-1:0];
				if (wrap && fin_s4.bvalid) begin
					base_q <= sum_base[OFF_BITS] ? OFF_MAX : sum_base[OFF_BITS-1:0];
				end
				out_vld_q <= 1'b1;
			end else if (m_tready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire3 && prod_s3.last) begin
			part_s4 <= p_new;
			err_s4  <= e_new;
			fin_s4  <= prod_s3.fin;
		end
		if (fire4) begin
			out_src_q <= sum_src[OFF_BITS] ? OFF_MAX : sum_src[OFF_BITS-1:0];
			out_dst_q <= dest_q;
			out_len_q <= fin_s4.slice;
			out_err_q <= err_s4 || sat_fin || sum_src[OFF_BITS] || sum_dst[OFF_BITS];
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {out_len_q, out_dst_q, out_src_q};
	assign m_tuser  = out_err_q;

endmodule

[hw/rtl/gather_nd_address_generator_core.sv]
// Gather-ND address generator: takes one signed index component per item and,
// on the last component of each tuple, returns the source element offset, the
// destination offset and the slice length, with an error flag for an
// out-of-range component, bad geometry or saturation. It takes one item every
// cycle unless the output stalls or the strides settle; a result passes the
// input, range-check, multiply, accumulate and output registers after its
// tuple's last component enters. After reset and after every register write,
// s_tready stays low while the two registered stride multiplies settle;
// register writes are taken in any cycle. Depends on gnd_pkg and the gnd_cfg,
// gnd_issue, gnd_term and gnd_accum modules.
module gather_nd_address_generator_core import gnd_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [IDX_BITS-1:0]  s_tdata,   // [31:0] index_value
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [OUT_W-1:0]     m_tdata,   // [31:0] source_offset, [63:32] dest_offset,
	                                        // [95:64] slice_length
	output logic                 m_tuser,   // [0] index_error
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_wdata
);

	cfg_t  cfg;
	logic  v_s1;
	item_t item_s1;
	logic  rdy_term;
	logic  v_s3;
	prod_t prod_s3;
	logic  rdy_accum;

	gnd_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	gnd_issue u_issue (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.rdy_next (rdy_term),
		.v_s1     (v_s1),
		.item_s1  (item_s1)
	);

	gnd_term u_term (
		.clk      (clk),
		.arst_n   (arst_n),
		.v_s1     (v_s1),
		.item_s1  (item_s1),
		.rdy      (rdy_term),
		.rdy_next (rdy_accum),
		.v_s3     (v_s3),
		.prod_s3  (prod_s3)
	);

	gnd_accum u_accum (
		.clk      (clk),
		.arst_n   (arst_n),
		.v_s3     (v_s3),
		.prod_s3  (prod_s3),
		.rdy      (rdy_accum),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	// strides are stale right after a write, so no item may enter
	property p_cfg_holds_input;
		@(posedge clk) disable iff (!arst_n)
		cfg_we |=> !s_tready;
	endproperty
	a_cfg_holds_input: assert property (p_cfg_holds_input)
		else $error("item accepted while strides settle");

	// a slice length at the saturation value, or a destination offset that
	// already reached it, must carry the error flag
	property p_sat_flagged;
		@(posedge clk) disable iff (!arst_n)
		m_tvalid && ((m_tdata[OUT_W-1:2*OFF_BITS] == OFF_MAX) ||
			(m_tdata[2*OFF_BITS-1:OFF_BITS] == OFF_MAX)) |-> m_tuser;
	endproperty
	a_sat_flagged: assert property (p_sat_flagged)
		else $error("saturated result without error flag");

endmodule
